// File: rtl/core/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared widths, request and response types, and the saturation helper.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Width of one full product.
  localparam int PW = 2 * DATA_WIDTH;
  // Width of the scaled dividend magnitude.
  localparam int NW = 2 * DATA_WIDTH + 1 + FRAC_BITS;
  // Signed working width that holds every intermediate result.
  localparam int SW = NW + 1;
  localparam int CW = $clog2(NW + 1);

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_INC = 3'd4;

  typedef enum logic [2:0] {
    CL_ADD,
    CL_SUB,
    CL_MUL,
    CL_DIV,
    CL_DIVZ,
    CL_INC,
    CL_NONE
  } cls_t;

  typedef struct packed {
    logic [2:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] a_real;
    logic signed [DATA_WIDTH-1:0] a_imag;
    logic signed [DATA_WIDTH-1:0] b_real;
    logic signed [DATA_WIDTH-1:0] b_imag;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_real;
    logic signed [DATA_WIDTH-1:0] res_imag;
    logic                         overflow;
    logic                         div_by_zero;
  } rsp_t;

  typedef struct packed {
    cls_t                         cls;
    logic signed [DATA_WIDTH-1:0] ar;
    logic signed [DATA_WIDTH-1:0] ai;
    logic signed [DATA_WIDTH-1:0] br;
    logic signed [DATA_WIDTH-1:0] bi;
  } qent_t;

  typedef struct packed {
    logic [NW-1:0] mag_re;
    logic [NW-1:0] mag_im;
    logic          neg_re;
    logic          neg_im;
    logic [PW-1:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] val;
    logic                         ov;
  } sat_t;

  // 1.0 in the fixed-point format, one bit wider than a data word.
  localparam logic [DATA_WIDTH:0] ONE_FIX =
    {{(DATA_WIDTH - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // Clamp a wide signed value to the data word range.
  function automatic sat_t saturate(input logic signed [SW-1:0] v);
    sat_t s;
    logic fits;
    fits = (v[SW-1:DATA_WIDTH-1] == '0) || (v[SW-1:DATA_WIDTH-1] == '1);
    if (fits) begin
      s.val = v[DATA_WIDTH-1:0];
      s.ov  = 1'b0;
    end else begin
      s.val = v[SW-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                      : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      s.ov  = 1'b1;
    end
    return s;
  endfunction

endpackage

// File: rtl/core/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accepts requests, classifies the operation and queues them for the back end.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cau_pkg::req_t req,
  output cau_pkg::qent_t head,
  output logic          head_valid,
  input  logic          pop
);
  import cau_pkg::*;

  qent_t          entries [QDEPTH];
  logic [QPW-1:0] rd_ptr;
  logic [QPW-1:0] wr_ptr;
  logic [QPW:0]   count;
  logic           push;
  qent_t          ent_in;

  always_comb begin
    ent_in.ar = req.a_real;
    ent_in.ai = req.a_imag;
    ent_in.br = req.b_real;
    ent_in.bi = req.b_imag;
    unique case (req.req_type)
      OP_ADD:  ent_in.cls = CL_ADD;
      OP_SUB:  ent_in.cls = CL_SUB;
      OP_MUL:  ent_in.cls = CL_MUL;
      OP_DIV:  ent_in.cls = (req.b_real == '0 && req.b_imag == '0) ? CL_DIVZ : CL_DIV;
      OP_INC:  ent_in.cls = CL_INC;
      default: ent_in.cls = CL_NONE;
    endcase
  end

  assign busy       = (count == (QPW+1)'(QDEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= ent_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPW+1)'(push) - (QPW+1)'(pop);
    end
  end

endmodule

// File: rtl/core/cau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider
// Restoring divider, one quotient bit per cycle for both parts at once.
// ----------------------------------------------------------------------------
module cau_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cau_pkg::div_cmd_t cmd,
  output logic              busy,
  output logic              done,
  output cau_pkg::rsp_t     result
);
  import cau_pkg::*;

  logic [NW-1:0] n_re, n_im;
  logic [NW-1:0] q_re, q_im;
  logic [PW:0]   r_re, r_im;
  logic [PW-1:0] den;
  logic          neg_re, neg_im;
  logic [CW-1:0] cnt;

  logic [PW:0]   t_re, t_im;
  logic          ge_re, ge_im;
  logic signed [SW-1:0] qs_re, qs_im;
  sat_t          s_re, s_im;

  always_comb begin
    t_re  = {r_re[PW-1:0], n_re[NW-1]};
    t_im  = {r_im[PW-1:0], n_im[NW-1]};
    ge_re = (t_re >= {1'b0, den});
    ge_im = (t_im >= {1'b0, den});
    qs_re = neg_re ? -signed'({1'b0, q_re}) : signed'({1'b0, q_re});
    qs_im = neg_im ? -signed'({1'b0, q_im}) : signed'({1'b0, q_im});
    s_re  = saturate(qs_re);
    s_im  = saturate(qs_im);
    result.res_real    = s_re.val;
    result.res_imag    = s_im.val;
    result.overflow    = s_re.ov || s_im.ov;
    result.div_by_zero = 1'b0;
  end

  assign done = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (load) begin
      n_re   <= cmd.mag_re;
      n_im   <= cmd.mag_im;
      neg_re <= cmd.neg_re;
      neg_im <= cmd.neg_im;
      den    <= cmd.den;
      r_re   <= '0;
      r_im   <= '0;
      q_re   <= '0;
      q_im   <= '0;
    end else if (busy && cnt != '0) begin
      n_re <= {n_re[NW-2:0], 1'b0};
      n_im <= {n_im[NW-2:0], 1'b0};
      r_re <= ge_re ? t_re - {1'b0, den} : t_re;
      r_im <= ge_im ? t_im - {1'b0, den} : t_im;
      q_re <= {q_re[NW-2:0], ge_re};
      q_im <= {q_im[NW-2:0], ge_im};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Product stage, result formation, divider sequencing and the output register.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic           clk,
  input  logic           rst,
  input  cau_pkg::qent_t head,
  input  logic           head_valid,
  output logic           pop,
  output cau_pkg::rsp_t  rsp,
  output logic           rsp_valid
);
  import cau_pkg::*;

  logic                 s1_valid;
  qent_t                s1;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bbr, p_bbi;

  logic                 div_busy, div_done, div_load;
  div_cmd_t             div_cmd;
  rsp_t                 div_rsp;
  logic                 advance, out_fire;
  rsp_t                 rsp_next;

  logic signed [SW-1:0] w_re, w_im, nr, ni;
  logic [SW-1:0]        m_re, m_im;
  sat_t                 s_re, s_im;

  assign advance  = !div_busy;
  assign pop      = head_valid && advance;
  assign out_fire = s1_valid && advance && (s1.cls != CL_DIV);
  assign div_load = s1_valid && advance && (s1.cls == CL_DIV);

  always_comb begin
    nr = SW'(p_rr) + SW'(p_ii);
    ni = SW'(p_ir) - SW'(p_ri);
    m_re = nr[SW-1] ? -nr : nr;
    m_im = ni[SW-1] ? -ni : ni;
    div_cmd.neg_re = nr[SW-1];
    div_cmd.neg_im = ni[SW-1];
    div_cmd.mag_re = {m_re[PW:0], {FRAC_BITS{1'b0}}};
    div_cmd.mag_im = {m_im[PW:0], {FRAC_BITS{1'b0}}};
    div_cmd.den    = $unsigned(p_bbr) + $unsigned(p_bbi);

    w_re = '0;
    w_im = '0;
    unique case (s1.cls)
      CL_ADD: begin
        w_re = SW'(s1.ar) + SW'(s1.br);
        w_im = SW'(s1.ai) + SW'(s1.bi);
      end
      CL_SUB: begin
        w_re = SW'(s1.ar) - SW'(s1.br);
        w_im = SW'(s1.ai) - SW'(s1.bi);
      end
      CL_MUL: begin
        w_re = (SW'(p_rr) - SW'(p_ii)) >>> FRAC_BITS;
        w_im = (SW'(p_ri) + SW'(p_ir)) >>> FRAC_BITS;
      end
      CL_INC: begin
        w_re = SW'(s1.ar) + SW'(signed'(ONE_FIX));
        w_im = SW'(s1.ai) + SW'(signed'(ONE_FIX));
      end
      default: begin
        w_re = '0;
        w_im = '0;
      end
    endcase
    s_re = saturate(w_re);
    s_im = saturate(w_im);
    rsp_next.res_real    = s_re.val;
    rsp_next.res_imag    = s_im.val;
    rsp_next.overflow    = s_re.ov || s_im.ov;
    rsp_next.div_by_zero = (s1.cls == CL_DIVZ);
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1    <= head;
      p_rr  <= head.ar * head.br;
      p_ii  <= head.ai * head.bi;
      p_ri  <= head.ar * head.bi;
      p_ir  <= head.ai * head.br;
      p_bbr <= head.br * head.br;
      p_bbi <= head.bi * head.bi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid <= pop;
      end
      rsp_valid <= out_fire || div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      rsp <= div_rsp;
    end else if (out_fire) begin
      rsp <= rsp_next;
    end
  end

  cau_div u_div (
    .clk    (clk),
    .rst    (rst),
    .load   (div_load),
    .cmd    (div_cmd),
    .busy   (div_busy),
    .done   (div_done),
    .result (div_rsp)
  );

`ifndef SYNTH
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.div_by_zero |-> rsp.res_real == '0 && rsp.res_imag == '0
      && !rsp.overflow)
    else $error("divide by zero result is not clean zero");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    div_load |=> div_busy && !rsp_valid)
    else $error("divider did not start after load");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    div_done |=> !div_busy && rsp_valid)
    else $error("divider completion not delivered");
`endif

endmodule

// File: rtl/core/complex_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide and increment on signed Q16.16 complex data.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// The request carries the operation code and both complex operands.
// Each request yields exactly one response, shown on rsp for one cycle with
// rsp_valid high; the receiver must take it then, it cannot hold it off.
// Responses leave in request order.
// Requests first enter a four-entry queue. While no divide is in progress,
// the back end pops one request per cycle into a product stage (six 32x32
// multipliers) and then forms the saturated result in the output register.
// Add, subtract, multiply and increment thus sustain one request per cycle
// under the same condition; a divide by zero passes the same stages.
// A divide runs through a restoring divider that yields one quotient bit per
// cycle over the 81-bit scaled dividend. The back end takes no further
// request until the divide is done, while the queue still accepts requests;
// busy rises once the queue is full.
// Reset empties the queue and pipeline; no response is pending after it.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cau_pkg::req_t req,
  output cau_pkg::rsp_t rsp,
  output logic          rsp_valid
);
  import cau_pkg::*;

  // Queue head handed from the front end to the back end.
  qent_t head;
  logic  head_valid;
  logic  pop;

  cau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // The back end stalls only while a divide is in progress.
  cau_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .rsp        (rsp),
    .rsp_valid  (rsp_valid)
  );

endmodule

// File: dv/complex_arithmetic_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives requests of every operation with random gaps and checks every
// response, in order, against a predictor of the exact saturated result.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core_tb;
  import cau_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  req_t  req;
  rsp_t  rsp;
  logic  rsp_valid;

  // Responses predicted for the requests taken so far, oldest first.
  rsp_t  pending_rsp[$];
  int    mismatch_count;
  int    idle_cycles;

  complex_arithmetic_unit_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Clamp an exact 128-bit value to one data word and note any clipping.
  function automatic logic signed [DATA_WIDTH-1:0] clamp_word(
      input logic signed [127:0] v, inout logic ov);
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = (128'sd1 <<< (DATA_WIDTH - 1)) - 1;
    lo_lim = -(128'sd1 <<< (DATA_WIDTH - 1));
    if (v > hi_lim) begin
      ov = 1'b1;
      return hi_lim[DATA_WIDTH-1:0];
    end
    if (v < lo_lim) begin
      ov = 1'b1;
      return lo_lim[DATA_WIDTH-1:0];
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  // Signed division truncated toward zero, done on magnitudes.
  function automatic logic signed [127:0] quot_trunc(
      input logic signed [127:0] n, input logic signed [127:0] d);
    logic [127:0] q;
    q = (n < 0 ? -n : n) / d;
    return n < 0 ? -$signed(q) : $signed(q);
  endfunction

  // Exact complex result of one request, saturated to the data word.
  function automatic rsp_t complex_result(input req_t r);
    rsp_t o;
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    logic ov;
    ar = r.a_real;
    ai = r.a_imag;
    br = r.b_real;
    bi = r.b_imag;
    re = '0;
    im = '0;
    ov = 1'b0;
    o  = '0;
    case (r.req_type)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        // Arithmetic shift rounds toward minus infinity.
        re = (ar * br - ai * bi) >>> FRAC_BITS;
        im = (ar * bi + ai * br) >>> FRAC_BITS;
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          o.div_by_zero = 1'b1;
          return o;
        end
        den = br * br + bi * bi;
        re  = quot_trunc((ar * br + ai * bi) <<< FRAC_BITS, den);
        im  = quot_trunc((ai * br - ar * bi) <<< FRAC_BITS, den);
      end
      OP_INC: begin
        re = ar + (128'sd1 <<< FRAC_BITS);
        im = ai + (128'sd1 <<< FRAC_BITS);
      end
      default: return o;
    endcase
    o.res_real = clamp_word(re, ov);
    o.res_imag = clamp_word(im, ov);
    o.overflow = ov;
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Response checker: every strobe is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        rsp_t exp_rsp;
        exp_rsp = pending_rsp.pop_front();
        if (rsp.res_real !== exp_rsp.res_real)
          report_mismatch($sformatf("res_real %h expected %h", rsp.res_real,
                                    exp_rsp.res_real));
        if (rsp.res_imag !== exp_rsp.res_imag)
          report_mismatch($sformatf("res_imag %h expected %h", rsp.res_imag,
                                    exp_rsp.res_imag));
        if (rsp.overflow !== exp_rsp.overflow)
          report_mismatch($sformatf("overflow %b expected %b", rsp.overflow,
                                    exp_rsp.overflow));
        if (rsp.div_by_zero !== exp_rsp.div_by_zero)
          report_mismatch($sformatf("div_by_zero %b expected %b",
                                    rsp.div_by_zero, exp_rsp.div_by_zero));
      end
    end
  end

  // Watchdog: counts cycles with neither a request taken nor a response.
  always @(posedge clk) begin
    if (rst || (start && !busy) || rsp_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // No gap half the time, else mostly a short one, now and then a long one.
  function automatic int gap_length();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: n = 0;
      5, 6, 7, 8:    n = $urandom_range(1, 3);
      default:       n = $urandom_range(10, 40);
    endcase
    return n;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input req_t r, input bit with_gap);
    int n;
    n = with_gap ? gap_length() : 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(complex_result(r));
  endtask

  function automatic req_t make_req(input logic [2:0] op,
      input logic [31:0] ar, input logic [31:0] ai,
      input logic [31:0] br, input logic [31:0] bi);
    req_t r;
    r.req_type = op;
    r.a_real   = ar;
    r.a_imag   = ai;
    r.b_real   = br;
    r.b_imag   = bi;
    return r;
  endfunction

  // Operand with a mix of extremes, small values and full random words.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 32'h0003_ffff);
      4: return -$urandom_range(0, 32'h0003_ffff);
      5: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    send_request(make_req(OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          32'hffff_0000), 1'b0);
    send_request(make_req(OP_ADD, mx, mn, 32'd1, 32'hffff_ffff), 1'b0);
    send_request(make_req(OP_ADD, mn, mx, mn, mx), 1'b0);
    send_request(make_req(OP_SUB, mx, mn, 32'hffff_ffff, 32'd1), 1'b0);
    send_request(make_req(OP_SUB, 32'd5, 32'd7, 32'd7, 32'd5), 1'b0);
    send_request(make_req(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                          32'hfffb_0000), 1'b0);
    // Products rounded toward minus infinity on negative results.
    send_request(make_req(OP_MUL, 32'hffff_ffff, 32'd0, 32'd1, 32'd3), 1'b0);
    send_request(make_req(OP_MUL, mx, mx, mx, mx), 1'b0);
    send_request(make_req(OP_MUL, mn, mn, mn, mn), 1'b0);
    send_request(make_req(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                          32'h0000_0000), 1'b0);
    // Zero divisor gives zero and the divide-by-zero flag.
    send_request(make_req(OP_DIV, mx, mn, 32'd0, 32'd0), 1'b0);
    send_request(make_req(OP_DIV, mx, mn, 32'd1, 32'd0), 1'b0);
    send_request(make_req(OP_DIV, mn, mn, 32'd0, 32'hffff_ffff), 1'b0);
    send_request(make_req(OP_DIV, 32'hfffe_8000, 32'd3, mn, mx), 1'b0);
    // Increment ignores the second operand and saturates at the top.
    send_request(make_req(OP_INC, mx, 32'hffff_0000, mn, mx), 1'b0);
    send_request(make_req(OP_INC, mn, 32'h7fff_0000, 32'd0, 32'd0), 1'b0);
    // Unused selectors give an all-zero response.
    send_request(make_req(3'd5, mx, mn, mx, mn), 1'b0);
    send_request(make_req(3'd6, 32'd1, 32'd1, 32'd1, 32'd1), 1'b0);
    send_request(make_req(3'd7, mn, mx, mn, mx), 1'b0);
  endtask

  task automatic test_random(input int count);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      // Divides are slow, so they get a smaller share than add, subtract and multiply.
      case ($urandom_range(0, 15))
        0, 1, 2:    op = OP_ADD;
        3, 4, 5:    op = OP_SUB;
        6, 7, 8, 9: op = OP_MUL;
        10, 11:     op = OP_DIV;
        12, 13:     op = OP_INC;
        default:    op = 3'($urandom_range(0, 7));
      endcase
      send_request(make_req(op, pick_operand(), pick_operand(), pick_operand(),
                            pick_operand()), $urandom_range(0, 2) == 0);
    end
    start <= 1'b0;
  endtask

  task automatic drain_responses();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    mismatch_count = 0;
    idle_cycles    = 0;
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    drain_responses();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_div.sv
rtl/core/cau_back.sv
rtl/core/complex_arithmetic_unit_core.sv
dv/complex_arithmetic_unit_core_tb.sv
